// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers; the bodies drop out for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check prop at every rising edge outside reset.
`define SCGR_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check cons in the cycle after ante, outside reset.
`define SCGR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) ante |=> cons) else $error(msg);

`else

`define SCGR_ASSERT(lbl, clk, rst_n, prop, msg)
`define SCGR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== rtl/core/scgr_pkg.sv =====
// ----------------------------------------------------------------------------
// Stereo capture gate package
// Widths, register defaults, codes and shared types of the capture gate.
// ----------------------------------------------------------------------------
package scgr_pkg;

    localparam int SAMPLE_BITS    = 24;
    localparam int INDEX_BITS     = 20;
    localparam int ENERGY_BITS    = 59;
    localparam int THRESH_BITS    = 23;
    localparam int WINDOW_BITS    = 13;
    localparam int CFG_DATA_BITS  = ENERGY_BITS;
    localparam int CFG_INDEX_BITS = 2;
    localparam int SQ_BITS        = 2 * SAMPLE_BITS;
    localparam int DEF_MAX_WINDOW = 4096;

    localparam logic [THRESH_BITS-1:0] RST_THRESHOLD = THRESH_BITS'(26527);
    localparam logic [ENERGY_BITS-1:0] RST_LIMIT     = ENERGY_BITS'(27487790);
    localparam logic [WINDOW_BITS-1:0] RST_WINDOW    = WINDOW_BITS'(2400);
    localparam logic [INDEX_BITS-1:0]  RST_CAPTURE   = INDEX_BITS'(480000);

    typedef enum logic [1:0] {
        CAUSE_NONE  = 2'd0,
        CAUSE_FULL  = 2'd1,
        CAUSE_QUIET = 2'd2
    } cause_t;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_IN_THRESHOLD     = 2'd0,
        REG_OUT_ENERGY_LIMIT = 2'd1,
        REG_WINDOW_FRAMES    = 2'd2,
        REG_CAPTURE_FRAMES   = 2'd3
    } cfg_reg_t;

    // Per-frame decision of the front control.
    typedef struct packed {
        logic                  store;
        logic                  sub;
        logic                  full;
        logic                  qchk;
        logic [INDEX_BITS-1:0] idx;
        logic [INDEX_BITS-1:0] count;
    } frame_dec_t;

    // Pipeline stage payload.
    typedef struct packed {
        frame_dec_t                    dec;
        logic signed [SAMPLE_BITS-1:0] left;
        logic signed [SAMPLE_BITS-1:0] right;
    } stage_t;

    // Energy lane controls.
    typedef struct packed {
        logic load;
        logic sq_en;
        logic acc_en;
        logic acc_clr;
        logic sub;
        logic q_clr;
    } lane_ctl_t;

    function automatic logic [SAMPLE_BITS-1:0] magnitude(
        input logic signed [SAMPLE_BITS-1:0] s
    );
        logic [SAMPLE_BITS-1:0] m;
        m = s[SAMPLE_BITS-1] ? SAMPLE_BITS'(-s) : SAMPLE_BITS'(s);
        return m;
    endfunction

endpackage

// ===== rtl/core/scgr_if.sv =====
// ----------------------------------------------------------------------------
// Stereo capture gate channels
// Valid/ready channels for input frames and for result beats.
// ----------------------------------------------------------------------------
interface scgr_in_if;
    logic                                       valid;
    logic                                       ready;
    logic signed [scgr_pkg::SAMPLE_BITS-1:0]    left_sample;
    logic signed [scgr_pkg::SAMPLE_BITS-1:0]    right_sample;
    logic                                       period_end;

    modport source (output valid, output left_sample, output right_sample,
                    output period_end, input ready);
    modport sink   (input valid, input left_sample, input right_sample,
                    input period_end, output ready);
endinterface

interface scgr_out_if;
    logic                                       valid;
    logic                                       ready;
    logic                                       store_valid;
    logic [scgr_pkg::INDEX_BITS-1:0]            store_index;
    logic signed [scgr_pkg::SAMPLE_BITS-1:0]    left_store;
    logic signed [scgr_pkg::SAMPLE_BITS-1:0]    right_store;
    logic                                       capture_done;
    logic [1:0]                                 done_cause;
    logic [scgr_pkg::INDEX_BITS-1:0]            frames_captured;

    modport source (output valid, output store_valid, output store_index,
                    output left_store, output right_store, output capture_done,
                    output done_cause, output frames_captured, input ready);
    modport sink   (input valid, input store_valid, input store_index,
                    input left_store, input right_store, input capture_done,
                    input done_cause, input frames_captured, output ready);
endinterface

// ===== rtl/core/scgr_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One address per cycle, registered read, old data returned on a write.
// ----------------------------------------------------------------------------
module scgr_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 4096,
    localparam int ADDR_BITS = $clog2(DEPTH)
) (
    input  logic                 clk,
    input  logic                 en,
    input  logic                 we,
    input  logic [ADDR_BITS-1:0] addr,
    input  logic [WIDTH-1:0]     wdata,
    output logic [WIDTH-1:0]     rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rdata_reg <= mem_reg[addr];
            if (we)
            begin
                mem_reg[addr] <= wdata;
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/scgr_ctrl.sv =====
// ----------------------------------------------------------------------------
// Capture front control
// Trigger, frame count and history pointer; decides store and finish per beat.
// ----------------------------------------------------------------------------
module scgr_ctrl #(
    parameter int MAX_WINDOW = scgr_pkg::DEF_MAX_WINDOW,
    localparam int PTR_BITS = $clog2(MAX_WINDOW),
    localparam int WB = PTR_BITS + 1
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    accept,
    input  logic                                    rearm,
    input  logic signed [scgr_pkg::SAMPLE_BITS-1:0] left_sample,
    input  logic signed [scgr_pkg::SAMPLE_BITS-1:0] right_sample,
    input  logic                                    period_end,
    input  logic [scgr_pkg::THRESH_BITS-1:0]        threshold,
    input  logic [scgr_pkg::WINDOW_BITS-1:0]        window_frames,
    input  logic [scgr_pkg::INDEX_BITS-1:0]         capture_frames,
    output scgr_pkg::frame_dec_t                    dec,
    output logic [PTR_BITS-1:0]                     addr,
    output logic [WB-1:0]                           window_eff
);

    localparam int IB = scgr_pkg::INDEX_BITS;

    logic            trig_reg;
    logic [IB-1:0]   fw_reg;
    logic [PTR_BITS-1:0] ptr_reg;

    logic [WB-1:0]   win_clamped;
    logic [WB-1:0]   w_eff;
    logic [IB-1:0]   w_ext;
    logic [IB-1:0]   cap_eff;
    logic            hit;
    logic            trig;
    logic            store;
    logic [PTR_BITS-1:0] p0;
    logic [WB-1:0]   p_inc;
    logic [IB-1:0]   fw_next;
    logic [PTR_BITS-1:0] ptr_next;
    logic            full;

    always_comb
    begin
        win_clamped = (32'(window_frames) > MAX_WINDOW) ? WB'(MAX_WINDOW)
                                                        : WB'(window_frames);
        w_eff   = (window_frames == '0) ? WB'(1) : win_clamped;
        w_ext   = IB'(w_eff);
        cap_eff = (capture_frames == '0) ? IB'(1) : capture_frames;

        hit = (scgr_pkg::magnitude(left_sample)
               > scgr_pkg::SAMPLE_BITS'(threshold))
           || (scgr_pkg::magnitude(right_sample)
               > scgr_pkg::SAMPLE_BITS'(threshold));
        trig  = trig_reg || hit;
        store = trig && (fw_reg < cap_eff);

        p0      = (WB'(ptr_reg) >= w_eff) ? '0 : ptr_reg;
        p_inc   = WB'(p0) + WB'(1);
        fw_next = store ? fw_reg + IB'(1) : fw_reg;

        if (store)
        begin
            ptr_next = (p_inc >= w_eff) ? '0 : p_inc[PTR_BITS-1:0];
        end
        else
        begin
            ptr_next = ptr_reg;
        end

        full = period_end && trig && (fw_next >= cap_eff);

        dec.store = store;
        dec.sub   = store && (fw_next > w_ext);
        dec.full  = full;
        dec.qchk  = period_end && trig && !full && (fw_next >= w_ext);
        dec.idx   = store ? fw_reg : '0;
        dec.count = fw_next;
    end

    assign addr       = p0;
    assign window_eff = w_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trig_reg <= 1'b0;
            fw_reg   <= '0;
            ptr_reg  <= '0;
        end
        else if (rearm || (accept && full))
        begin
            trig_reg <= 1'b0;
            fw_reg   <= '0;
            ptr_reg  <= '0;
        end
        else if (accept)
        begin
            trig_reg <= trig;
            fw_reg   <= fw_next;
            ptr_reg  <= ptr_next;
        end
    end

endmodule

// ===== rtl/core/scgr_lane.sv =====
// ----------------------------------------------------------------------------
// Energy lane
// Squares new and expiring samples of one channel, keeps the windowed energy.
// ----------------------------------------------------------------------------
module scgr_lane (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  scgr_pkg::lane_ctl_t                     ctl,
    input  logic signed [scgr_pkg::SAMPLE_BITS-1:0] sample,
    input  logic signed [scgr_pkg::SAMPLE_BITS-1:0] old_sample,
    input  logic [scgr_pkg::ENERGY_BITS-1:0]        limit,
    output logic                                    quiet
);

    localparam int EB  = scgr_pkg::ENERGY_BITS;
    localparam int AB  = EB + 1;
    localparam int SB  = scgr_pkg::SAMPLE_BITS;
    localparam int QB  = scgr_pkg::SQ_BITS;

    logic [SB-1:0] mag_reg;
    logic [QB-1:0] new_sq_reg;
    logic [QB-1:0] old_sq_reg;
    logic [EB-1:0] energy_reg;

    logic [SB-1:0] old_mag;
    logic [AB-1:0] e_ext;
    logic [AB-1:0] new_ext;
    logic [AB-1:0] old_ext;
    logic [AB-1:0] sum;
    logic          below;
    logic [EB-1:0] acc_val;
    logic [EB-1:0] energy_next;

    assign old_mag = scgr_pkg::magnitude(old_sample);

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            mag_reg <= scgr_pkg::magnitude(sample);
        end
        if (ctl.sq_en)
        begin
            new_sq_reg <= QB'(mag_reg) * QB'(mag_reg);
            old_sq_reg <= QB'(old_mag) * QB'(old_mag);
        end
    end

    always_comb
    begin
        e_ext   = AB'(energy_reg);
        new_ext = AB'(new_sq_reg);
        old_ext = AB'(old_sq_reg);
        below   = ctl.sub && (e_ext < old_ext);
        sum     = e_ext + new_ext - (ctl.sub ? old_ext : '0);

        if (below)
        begin
            acc_val = EB'(new_sq_reg);
        end
        else if (sum[EB])
        begin
            acc_val = '1;
        end
        else
        begin
            acc_val = sum[EB-1:0];
        end

        if (ctl.q_clr)
        begin
            energy_next = '0;
        end
        else if (ctl.acc_en)
        begin
            energy_next = ctl.acc_clr ? '0 : acc_val;
        end
        else
        begin
            energy_next = energy_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            energy_reg <= '0;
        end
        else
        begin
            energy_reg <= energy_next;
        end
    end

    assign quiet = (energy_reg <= limit);

endmodule

// ===== rtl/core/stereo_capture_gate_rms_core.sv =====
// ----------------------------------------------------------------------------
// Pipeline: an accepted frame passes s1_reg, s2_reg, s3_reg and the output registers.
// Throughput: one frame per cycle while the result side is ready; after a period-end
//   frame that arms the quiet check, intake is held until that frame leaves s3_reg, for
//   the energy accumulate and compare loop in the lanes to settle the release decision.
// Reset: clears configuration to defaults, trigger, counters, energies and the
//   pipeline; the history memory is not cleared and is undefined until written.
// ----------------------------------------------------------------------------
// ----------------------------------------------------------------------------
// Stereo capture gate top level
// Trigger, two energy lanes over a shared history RAM, and the release merge.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module stereo_capture_gate_rms_core #(
    parameter int MAX_WINDOW = scgr_pkg::DEF_MAX_WINDOW
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [scgr_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [scgr_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    scgr_in_if.sink                               frame_in,
    scgr_out_if.source                            result_out
);

    localparam int PTR_BITS = $clog2(MAX_WINDOW);
    localparam int WB       = PTR_BITS + 1;
    localparam int SB       = scgr_pkg::SAMPLE_BITS;
    localparam int IB       = scgr_pkg::INDEX_BITS;

    logic [scgr_pkg::THRESH_BITS-1:0] thresh_reg;
    logic [scgr_pkg::ENERGY_BITS-1:0] limit_reg;
    logic [scgr_pkg::WINDOW_BITS-1:0] window_reg;
    logic [IB-1:0]                    capture_reg;

    logic v1_reg, v2_reg, v3_reg;
    logic busy_reg;
    scgr_pkg::stage_t s1_reg, s2_reg, s3_reg;

    logic                  out_valid_reg;
    logic                  out_store_valid_reg;
    logic [IB-1:0]         out_index_reg;
    logic signed [SB-1:0]  out_left_reg;
    logic signed [SB-1:0]  out_right_reg;
    scgr_pkg::cause_t      out_cause_reg;
    logic [IB-1:0]         out_frames_reg;

    logic en0, en1, en2, en3;
    logic accept;
    logic rearm_q;
    logic quiet_l, quiet_r;
    scgr_pkg::frame_dec_t  dec;
    scgr_pkg::lane_ctl_t   lane_ctl;
    scgr_pkg::cause_t      cause3;
    logic [PTR_BITS-1:0]   hist_addr;
    logic [WB-1:0]         window_eff;
    logic [2*SB-1:0]       hist_rdata;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg  <= scgr_pkg::RST_THRESHOLD;
            limit_reg   <= scgr_pkg::RST_LIMIT;
            window_reg  <= scgr_pkg::RST_WINDOW;
            capture_reg <= scgr_pkg::RST_CAPTURE;
        end
        else if (cfg_we)
        begin
            unique case (scgr_pkg::cfg_reg_t'(cfg_index))
                scgr_pkg::REG_IN_THRESHOLD:
                    thresh_reg <= cfg_data[scgr_pkg::THRESH_BITS-1:0];
                scgr_pkg::REG_OUT_ENERGY_LIMIT:
                    limit_reg <= cfg_data[scgr_pkg::ENERGY_BITS-1:0];
                scgr_pkg::REG_WINDOW_FRAMES:
                    window_reg <= cfg_data[scgr_pkg::WINDOW_BITS-1:0];
                scgr_pkg::REG_CAPTURE_FRAMES:
                    capture_reg <= cfg_data[IB-1:0];
            endcase
        end
    end

    // stage enables: advance into an empty or moving stage
    assign en3 = !out_valid_reg || result_out.ready;
    assign en2 = !v3_reg || en3;
    assign en1 = !v2_reg || en2;
    assign en0 = !v1_reg || en1;

    assign frame_in.ready = en0 && !busy_reg;
    assign accept         = frame_in.valid && frame_in.ready;

    scgr_ctrl #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .rearm          (rearm_q),
        .left_sample    (frame_in.left_sample),
        .right_sample   (frame_in.right_sample),
        .period_end     (frame_in.period_end),
        .threshold      (thresh_reg),
        .window_frames  (window_reg),
        .capture_frames (capture_reg),
        .dec            (dec),
        .addr           (hist_addr),
        .window_eff     (window_eff)
    );

    scgr_ram #(
        .WIDTH (2 * SB),
        .DEPTH (MAX_WINDOW)
    ) u_hist (
        .clk   (clk),
        .en    (accept),
        .we    (dec.store),
        .addr  (hist_addr),
        .wdata ({frame_in.left_sample, frame_in.right_sample}),
        .rdata (hist_rdata)
    );

    always_comb
    begin
        lane_ctl.load    = en0;
        lane_ctl.sq_en   = en1;
        lane_ctl.acc_en  = en2 && v2_reg && (s2_reg.dec.store || s2_reg.dec.full);
        lane_ctl.acc_clr = s2_reg.dec.full;
        lane_ctl.sub     = s2_reg.dec.sub;
        lane_ctl.q_clr   = rearm_q;
    end

    scgr_lane u_lane_l (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (lane_ctl),
        .sample     (frame_in.left_sample),
        .old_sample (hist_rdata[2*SB-1:SB]),
        .limit      (limit_reg),
        .quiet      (quiet_l)
    );

    scgr_lane u_lane_r (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (lane_ctl),
        .sample     (frame_in.right_sample),
        .old_sample (hist_rdata[SB-1:0]),
        .limit      (limit_reg),
        .quiet      (quiet_r)
    );

    // merge the lane verdicts into the finish cause
    always_comb
    begin
        if (s3_reg.dec.full)
        begin
            cause3 = scgr_pkg::CAUSE_FULL;
        end
        else if (s3_reg.dec.qchk && quiet_l && quiet_r)
        begin
            cause3 = scgr_pkg::CAUSE_QUIET;
        end
        else
        begin
            cause3 = scgr_pkg::CAUSE_NONE;
        end
    end

    assign rearm_q = en3 && v3_reg && (cause3 == scgr_pkg::CAUSE_QUIET);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            busy_reg      <= 1'b0;
        end
        else
        begin
            if (en0)
            begin
                v1_reg <= accept;
            end
            if (en1)
            begin
                v2_reg <= v1_reg;
            end
            if (en2)
            begin
                v3_reg <= v2_reg;
            end
            if (en3)
            begin
                out_valid_reg <= v3_reg;
            end
            // hold intake until the quiet decision lands
            if (accept && dec.qchk)
            begin
                busy_reg <= 1'b1;
            end
            else if (en3 && v3_reg && s3_reg.dec.qchk)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en0)
        begin
            s1_reg.dec   <= dec;
            s1_reg.left  <= dec.store ? frame_in.left_sample : '0;
            s1_reg.right <= dec.store ? frame_in.right_sample : '0;
        end
        if (en1)
        begin
            s2_reg <= s1_reg;
        end
        if (en2)
        begin
            s3_reg <= s2_reg;
        end
        if (en3)
        begin
            out_store_valid_reg <= s3_reg.dec.store;
            out_index_reg       <= s3_reg.dec.idx;
            out_left_reg        <= s3_reg.left;
            out_right_reg       <= s3_reg.right;
            out_cause_reg       <= cause3;
            out_frames_reg      <= s3_reg.dec.count;
        end
    end

    assign result_out.valid           = out_valid_reg;
    assign result_out.store_valid     = out_store_valid_reg;
    assign result_out.store_index     = out_index_reg;
    assign result_out.left_store      = out_left_reg;
    assign result_out.right_store     = out_right_reg;
    assign result_out.capture_done    = (out_cause_reg != scgr_pkg::CAUSE_NONE);
    assign result_out.done_cause      = out_cause_reg;
    assign result_out.frames_captured = out_frames_reg;

    `SCGR_ASSERT(a_rearm_drained, clk, rst_n, rearm_q |-> (!v1_reg && !v2_reg), "quiet rearm with frames in flight")
    `SCGR_ASSERT(a_index_count, clk, rst_n, (out_valid_reg && out_store_valid_reg) |-> (out_frames_reg == out_index_reg + IB'(1)), "store index and frame count disagree")
    `SCGR_ASSERT(a_quiet_window, clk, rst_n, (out_valid_reg && out_cause_reg == scgr_pkg::CAUSE_QUIET) |-> (out_frames_reg >= IB'(window_eff)), "quiet release before a full window")
    `SCGR_ASSERT_NEXT(a_busy_set, clk, rst_n, (accept && dec.qchk), busy_reg, "intake not held after a quiet check frame")

endmodule

// ===== tb/sv/stereo_capture_gate_rms_core_tb.sv =====
// ----------------------------------------------------------------------------
// Stereo capture gate regression
// Streams stereo frames into the capture gate and checks every result beat
// against a cycle-free model of trigger, windowed energy and release. Directed
// cases cover the register extremes and the release corner cases; random
// phases replay silence/burst/edge/noise sequences under new settings, with random
// idling on both channels and one long result-side stall.
// ----------------------------------------------------------------------------
module stereo_capture_gate_rms_core_tb;

    import scgr_pkg::*;

    localparam int CLK_PERIOD     = 12;
    localparam int RESET_CYCLES   = 12;
    localparam int DRAIN_CYCLES   = 10;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int PHASE_FRAMES   = 85;
    localparam int MAX_WIN        = DEF_MAX_WINDOW;
    localparam int THR_MAX        = 8388607;

    localparam logic [63:0]            ENERGY_CEIL = (64'd1 << ENERGY_BITS) - 64'd1;
    localparam logic [ENERGY_BITS-1:0] LIMIT_MAX   = '1;

    typedef enum int {
        SEG_SILENT,
        SEG_BURST,
        SEG_EDGE,
        SEG_NOISE
    } seg_kind_t;

    typedef struct {
        logic                          store_valid;
        logic [INDEX_BITS-1:0]         store_index;
        logic signed [SAMPLE_BITS-1:0] left_store;
        logic signed [SAMPLE_BITS-1:0] right_store;
        logic                          capture_done;
        cause_t                        done_cause;
        logic [INDEX_BITS-1:0]         frames_captured;
    } capture_beat_t;

    logic clk = 1'b0;
    logic rst_n;
    logic                      cfg_we;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;

    scgr_in_if  frame_if ();
    scgr_out_if beat_if ();

    stereo_capture_gate_rms_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .frame_in   (frame_if),
        .result_out (beat_if)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // register copies
    logic [THRESH_BITS-1:0] thr_reg   = RST_THRESHOLD;
    logic [ENERGY_BITS-1:0] limit_reg = RST_LIMIT;
    logic [WINDOW_BITS-1:0] win_reg   = RST_WINDOW;
    logic [INDEX_BITS-1:0]  cap_reg   = RST_CAPTURE;

    // gate state
    logic                          gate_open     = 1'b0;
    logic [INDEX_BITS-1:0]         frames_stored = '0;
    logic [63:0]                   energy_l      = '0;
    logic [63:0]                   energy_r      = '0;
    int unsigned                   hist_ptr      = 0;
    logic signed [SAMPLE_BITS-1:0] hist_l [MAX_WIN];
    logic signed [SAMPLE_BITS-1:0] hist_r [MAX_WIN];
    bit                            hist_seen [MAX_WIN];

    capture_beat_t beats_due [$];
    int            mismatch_count = 0;
    int            beat_count     = 0;
    int            stall_cycles   = 0;
    bit            idle_en        = 1'b1;
    bit            hold_request   = 1'b0;
    int            hold_left      = 0;

    function automatic int unsigned eff_window(input logic [WINDOW_BITS-1:0] v);
        if (v == 0)
            return 1;
        if (v > MAX_WIN)
            return MAX_WIN;
        return v;
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] abs_sample(
        input logic signed [SAMPLE_BITS-1:0] s
    );
        logic [SAMPLE_BITS-1:0] u;
        u = s;
        return u[SAMPLE_BITS-1] ? (~u + 1'b1) : u;
    endfunction

    function automatic capture_beat_t predict_capture_beat(
        input logic signed [SAMPLE_BITS-1:0] l,
        input logic signed [SAMPLE_BITS-1:0] r,
        input logic                          pe
    );
        capture_beat_t          b;
        int unsigned            w;
        int unsigned            cap;
        logic [SAMPLE_BITS-1:0] ml;
        logic [SAMPLE_BITS-1:0] mr;
        logic [63:0]            sq;
        w   = eff_window(win_reg);
        cap = (cap_reg == 0) ? 1 : cap_reg;
        ml  = abs_sample(l);
        mr  = abs_sample(r);
        b.store_valid = 1'b0;
        b.store_index = '0;
        b.left_store  = '0;
        b.right_store = '0;
        b.done_cause  = CAUSE_NONE;
        if (!gate_open && (ml > thr_reg || mr > thr_reg))
            gate_open = 1'b1;
        if (gate_open && frames_stored < cap)
        begin
            b.store_valid = 1'b1;
            b.store_index = frames_stored;
            b.left_store  = l;
            b.right_store = r;
            frames_stored = frames_stored + 1'b1;
            if (hist_ptr >= w)
                hist_ptr = 0;
            if (frames_stored > w)
            begin
                sq = 64'(abs_sample(hist_l[hist_ptr])) * 64'(abs_sample(hist_l[hist_ptr]));
                energy_l = (sq > energy_l) ? 64'd0 : energy_l - sq;
                sq = 64'(abs_sample(hist_r[hist_ptr])) * 64'(abs_sample(hist_r[hist_ptr]));
                energy_r = (sq > energy_r) ? 64'd0 : energy_r - sq;
            end
            sq = 64'(ml) * 64'(ml);
            energy_l = (energy_l + sq > ENERGY_CEIL) ? ENERGY_CEIL : energy_l + sq;
            sq = 64'(mr) * 64'(mr);
            energy_r = (energy_r + sq > ENERGY_CEIL) ? ENERGY_CEIL : energy_r + sq;
            hist_l[hist_ptr]    = l;
            hist_r[hist_ptr]    = r;
            hist_seen[hist_ptr] = 1'b1;
            hist_ptr++;
            if (hist_ptr >= w)
                hist_ptr = 0;
        end
        if (pe && gate_open)
        begin
            if (frames_stored >= cap)
                b.done_cause = CAUSE_FULL;
            else if (frames_stored >= w && energy_l <= limit_reg && energy_r <= limit_reg)
                b.done_cause = CAUSE_QUIET;
        end
        b.capture_done    = (b.done_cause != CAUSE_NONE);
        b.frames_captured = frames_stored;
        if (b.capture_done)
        begin
            gate_open     = 1'b0;
            frames_stored = '0;
            energy_l      = '0;
            energy_r      = '0;
            hist_ptr      = 0;
        end
        return b;
    endfunction

    function automatic void compare_field(input string name, input logic [63:0] want,
                                          input logic [63:0] got);
        if (got !== want)
        begin
            $display("%0t: beat %0d %s expected %0h actual %0h",
                     $time, beat_count, name, want, got);
            mismatch_count++;
        end
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] random_sample(
        input int unsigned lo,
        input int unsigned hi
    );
        int v;
        v = $urandom_range(lo, hi);
        if ($urandom_range(0, 1))
            v = -v;
        return v[SAMPLE_BITS-1:0];
    endfunction

    task automatic push_frame(input logic signed [SAMPLE_BITS-1:0] l,
                              input logic signed [SAMPLE_BITS-1:0] r,
                              input logic pe);
        while (idle_en && $urandom_range(0, 99) < 17)
        begin
            frame_if.valid <= 1'b0;
            @(posedge clk);
        end
        frame_if.valid        <= 1'b1;
        frame_if.left_sample  <= l;
        frame_if.right_sample <= r;
        frame_if.period_end   <= pe;
        @(posedge clk);
        while (!frame_if.ready)
            @(posedge clk);
        beats_due.push_back(predict_capture_beat(l, r, pe));
    endtask

    task automatic settle_block();
        frame_if.valid <= 1'b0;
        while (beats_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_BITS-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_IN_THRESHOLD:     thr_reg   = val[THRESH_BITS-1:0];
            REG_OUT_ENERGY_LIMIT: limit_reg = val[ENERGY_BITS-1:0];
            REG_WINDOW_FRAMES:    win_reg   = val[WINDOW_BITS-1:0];
            REG_CAPTURE_FRAMES:   cap_reg   = val[INDEX_BITS-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic apply_config(input logic [THRESH_BITS-1:0] thr,
                                input logic [ENERGY_BITS-1:0] lim,
                                input logic [WINDOW_BITS-1:0] win,
                                input logic [INDEX_BITS-1:0]  cap);
        int unsigned w_new;
        bit          safe;
        settle_block();
        w_new = eff_window(win);
        safe  = 1'b1;
        // keep the window if a mid-capture change could reach unwritten history
        if (gate_open)
            for (int i = 0; i < w_new; i++)
                if (!hist_seen[i])
                    safe = 1'b0;
        if (!safe)
            win = win_reg;
        write_reg(REG_IN_THRESHOLD, CFG_DATA_BITS'(thr));
        write_reg(REG_OUT_ENERGY_LIMIT, CFG_DATA_BITS'(lim));
        write_reg(REG_WINDOW_FRAMES, CFG_DATA_BITS'(win));
        write_reg(REG_CAPTURE_FRAMES, CFG_DATA_BITS'(cap));
    endtask

    task automatic configure_random();
        logic [THRESH_BITS-1:0] thr;
        logic [ENERGY_BITS-1:0] lim;
        logic [WINDOW_BITS-1:0] win;
        logic [INDEX_BITS-1:0]  cap;
        int unsigned            pick;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            thr = $urandom_range(0, 2000);
        else if (pick < 80)
            thr = $urandom_range(0, 100000);
        else
            thr = $urandom_range(0, THR_MAX);
        pick = $urandom_range(0, 99);
        if (pick < 60)
            lim = $urandom_range(0, 50000000);
        else if (pick < 85)
            lim = ENERGY_BITS'({$urandom, $urandom});
        else if (pick < 92)
            lim = '0;
        else
            lim = LIMIT_MAX;
        pick = $urandom_range(0, 99);
        if (pick < 75)
            win = $urandom_range(1, 16);
        else if (pick < 85)
            win = $urandom_range(17, 64);
        else
        begin
            case ($urandom_range(0, 4))
                0:       win = 0;
                1:       win = 4096;
                2:       win = 8191;
                3:       win = 2400;
                default: win = 4097;
            endcase
        end
        pick = $urandom_range(0, 99);
        if (pick < 60)
            cap = $urandom_range(1, 80);
        else if (pick < 80)
            cap = $urandom_range(81, 1000);
        else
            cap = $urandom_range(0, 1048575);
        apply_config(thr, lim, win, cap);
    endtask

    // silence, bursts above threshold, threshold edges and raw noise
    task automatic stream_capture_traffic(input int unsigned n_frames);
        seg_kind_t                     kind;
        int unsigned                   seg_left;
        int unsigned                   period_len;
        int unsigned                   period_pos;
        int unsigned                   quiet_mag;
        int unsigned                   pick;
        logic signed [SAMPLE_BITS-1:0] l;
        logic signed [SAMPLE_BITS-1:0] r;
        logic                          pe;
        seg_left   = 0;
        period_pos = 0;
        period_len = $urandom_range(1, 8);
        kind       = SEG_SILENT;
        for (int i = 0; i < n_frames; i++)
        begin
            quiet_mag = (thr_reg < 1000) ? thr_reg : 1000;
            if (seg_left == 0)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 45)
                begin
                    kind     = SEG_SILENT;
                    seg_left = $urandom_range(1, 20);
                end
                else if (pick < 75)
                begin
                    kind     = SEG_BURST;
                    seg_left = $urandom_range(1, 30);
                end
                else if (pick < 85)
                begin
                    kind     = SEG_EDGE;
                    seg_left = 1;
                end
                else
                begin
                    kind     = SEG_NOISE;
                    seg_left = $urandom_range(1, 10);
                end
            end
            seg_left--;
            case (kind)
                SEG_SILENT:
                begin
                    l = random_sample(0, quiet_mag);
                    r = random_sample(0, quiet_mag);
                end
                SEG_BURST:
                begin
                    l = ($urandom_range(0, 3) != 0) ? random_sample(thr_reg + 1, THR_MAX + 1)
                                                    : random_sample(0, quiet_mag);
                    r = ($urandom_range(0, 3) != 0) ? random_sample(thr_reg + 1, THR_MAX + 1)
                                                    : random_sample(0, quiet_mag);
                end
                SEG_EDGE:
                begin
                    case ($urandom_range(0, 4))
                        0:       l = random_sample(thr_reg, thr_reg);
                        1:       l = random_sample(thr_reg + 1, thr_reg + 1);
                        2:       l = THR_MAX;
                        3:       l = -THR_MAX - 1;
                        default: l = '0;
                    endcase
                    r = random_sample(thr_reg, thr_reg + 1);
                    if ($urandom_range(0, 1))
                    begin
                        r = l;
                        l = random_sample(0, quiet_mag);
                    end
                end
                default:
                begin
                    l = $urandom;
                    r = $urandom;
                end
            endcase
            period_pos++;
            pe = (period_pos >= period_len);
            if (pe)
                period_pos = 0;
            if ($urandom_range(0, 99) < 8)
                pe = ~pe;
            push_frame(l, r, pe);
        end
    endtask

    task automatic test_reset_defaults();
        push_frame(0, 0, 1'b1);
        push_frame(26527, -26527, 1'b1);
        push_frame(-26528, 0, 1'b0);
        push_frame(THR_MAX, -THR_MAX - 1, 1'b1);
        // shrink window and memory mid-capture: next period end sees memory full
        apply_config(RST_THRESHOLD, RST_LIMIT, 1, 0);
        push_frame(5, -5, 1'b1);
    endtask

    task automatic test_full_and_quiet();
        apply_config(100, LIMIT_MAX, 2, 2);
        push_frame(200, 0, 1'b0);
        push_frame(0, 0, 1'b1);
        apply_config(100, 0, 1, 3);
        push_frame(300, 300, 1'b0);
        push_frame(1, -1, 1'b0);
        push_frame(-1, 1, 1'b0);
        push_frame(7, 7, 1'b0);
        push_frame(9, 9, 1'b1);
    endtask

    task automatic test_window_limits();
        apply_config(100, 10, 0, 1048575);
        push_frame(500, 0, 1'b0);
        push_frame(2, -2, 1'b1);
        apply_config(100, 10, 8191, 1048575);
        push_frame(-500, 500, 1'b1);
        apply_config(100, 10, 1, 1048575);
        push_frame(0, 0, 1'b1);
    endtask

    task automatic test_energy_floor();
        apply_config(100, 0, 4, 4);
        push_frame(8000, -8000, 1'b0);
        push_frame(8000, -8000, 1'b0);
        push_frame(8000, -8000, 1'b0);
        push_frame(8000, 8000, 1'b1);
        apply_config(100, 0, 2, 5);
        push_frame(200, 200, 1'b0);
        push_frame(1, 1, 1'b0);
        push_frame(1, 1, 1'b0);
        // grow the window onto loud history from the previous capture
        apply_config(100, 0, 4, 5);
        push_frame(1, 1, 1'b0);
        push_frame(1, 1, 1'b1);
    endtask

    task automatic test_random_captures();
        repeat (6)
        begin
            configure_random();
            stream_capture_traffic(PHASE_FRAMES);
        end
    endtask

    task automatic test_extreme_settings();
        apply_config(0, LIMIT_MAX, 1, 1);
        stream_capture_traffic(PHASE_FRAMES - 1);
        // rearm before the widest window
        push_frame(1, 1, 1'b1);
        apply_config(THR_MAX, 0, 4096, 1048575);
        stream_capture_traffic(PHASE_FRAMES);
    endtask

    task automatic test_no_idle_burst();
        configure_random();
        idle_en = 1'b0;
        stream_capture_traffic(PHASE_FRAMES);
        idle_en = 1'b1;
    endtask

    task automatic test_backpressure();
        configure_random();
        hold_request = 1'b1;
        stream_capture_traffic(PHASE_FRAMES);
    endtask

    initial
    begin
        beat_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                beat_if.ready <= 1'b0;
            end
            else
                beat_if.ready <= !(idle_en && $urandom_range(0, 99) < 17);
        end
    end

    always @(posedge clk)
    begin
        capture_beat_t want;
        if (rst_n && beat_if.valid && beat_if.ready)
        begin
            if (beats_due.size() == 0)
            begin
                $display("%0t: beat %0d expected none actual store_index %0h",
                         $time, beat_count, beat_if.store_index);
                mismatch_count++;
            end
            else
            begin
                want = beats_due.pop_front();
                compare_field("store_valid", 64'(want.store_valid), 64'(beat_if.store_valid));
                compare_field("store_index", 64'(want.store_index), 64'(beat_if.store_index));
                compare_field("left_store", 64'(want.left_store), 64'(beat_if.left_store));
                compare_field("right_store", 64'(want.right_store), 64'(beat_if.right_store));
                compare_field("capture_done", 64'(want.capture_done),
                              64'(beat_if.capture_done));
                compare_field("done_cause", 64'(want.done_cause), 64'(beat_if.done_cause));
                compare_field("frames_captured", 64'(want.frames_captured),
                              64'(beat_if.frames_captured));
            end
            beat_count++;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (frame_if.valid && frame_if.ready) || (beat_if.valid && beat_if.ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("stereo_capture_gate_rms_core regression: fail");
            $finish;
        end
    end

    initial
    begin
        rst_n                 <= 1'b0;
        cfg_we                <= 1'b0;
        cfg_index             <= REG_IN_THRESHOLD;
        cfg_data              <= '0;
        frame_if.valid        <= 1'b0;
        frame_if.left_sample  <= '0;
        frame_if.right_sample <= '0;
        frame_if.period_end   <= 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_full_and_quiet();
        test_window_limits();
        test_energy_floor();
        test_random_captures();
        test_extreme_settings();
        test_no_idle_burst();
        test_backpressure();
        settle_block();
        if (mismatch_count == 0 && beats_due.size() == 0)
            $display("stereo_capture_gate_rms_core regression: pass");
        else
            $display("stereo_capture_gate_rms_core regression: fail");
        $finish;
    end

endmodule
